/* rtl/ufhpc_pkg.sv */
// ufhpc_pkg: shared types, constants and the microcode rom of the union-find block
// no dependencies; used by every other file of the block but ufhpc_out_if
`default_nettype none

package ufhpc_pkg;

    localparam int unsigned COUNT_W  = 11;
    localparam int unsigned INDEX_W  = 10;
    localparam int unsigned HEIGHT_W = 4;

    localparam logic [COUNT_W-1:0]  COUNT_RESET = 11'd1024;
    localparam logic [HEIGHT_W-1:0] HEIGHT_ONE  = 4'd1;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX  = 4'd15;

    // program steps
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_WALK_A,
        ST_SET_CA,
        ST_COMP_A,
        ST_SET_B,
        ST_WALK_B,
        ST_SET_CB,
        ST_COMP_B,
        ST_SAME,
        ST_HEIGHT,
        ST_LINK,
        ST_PUSH
    } t_step;

    // walk pointer source
    typedef enum logic [2:0] {
        XS_HOLD,
        XS_A,
        XS_B,
        XS_RDATA,
        XS_INC
    } t_xsel;

    // parent table read address source
    typedef enum logic [1:0] {
        RS_A,
        RS_B,
        RS_RDATA
    } t_rsel;

    // table write kind
    typedef enum logic [1:0] {
        WS_NONE,
        WS_CLEAR,
        WS_COMPRESS,
        WS_LINK
    } t_wsel;

    // jump conditions
    typedef enum logic [2:0] {
        CN_NEVER,
        CN_ACCEPT,
        CN_ERR,
        CN_AT_ROOT,
        CN_X_ROOT,
        CN_NO_LINK,
        CN_LAST,
        CN_OUT_FREE
    } t_cond;

    typedef struct packed {
        t_xsel x_sel;
        t_rsel rd_sel;
        t_wsel wr_sel;
        logic  root_ld;
        logic  ra_ld;
        logic  rb_ld;
        logic  same_ld;
        logic  hra_ld;
        logic  hrd_rb;
        logic  load_in;
        logic  ready;
        logic  push;
        t_cond cond;
        logic  hold;
        t_step target;
    } t_ctrl;

    typedef struct packed {
        logic accept;
        logic err;
        logic at_root;
        logic x_root;
        logic no_link;
        logic last;
        logic out_free;
    } t_status;

    typedef struct packed {
        logic same_set;
        logic merged;
        logic range_error;
    } t_result;

    // microcode rom: one control word per step
    function automatic t_ctrl ucode(input t_step step);
        t_ctrl c;
        c.x_sel   = XS_HOLD;
        c.rd_sel  = RS_A;
        c.wr_sel  = WS_NONE;
        c.root_ld = 1'b0;
        c.ra_ld   = 1'b0;
        c.rb_ld   = 1'b0;
        c.same_ld = 1'b0;
        c.hra_ld  = 1'b0;
        c.hrd_rb  = 1'b0;
        c.load_in = 1'b0;
        c.ready   = 1'b0;
        c.push    = 1'b0;
        c.cond    = CN_NEVER;
        c.hold    = 1'b0;
        c.target  = ST_IDLE;
        unique case (step)
            ST_CLEAR: begin
                c.wr_sel = WS_CLEAR;
                c.x_sel  = XS_INC;
                c.cond   = CN_LAST;
                c.hold   = 1'b1;
                c.target = ST_IDLE;
            end
            ST_IDLE: begin
                c.ready   = 1'b1;
                c.load_in = 1'b1;
                c.cond    = CN_ACCEPT;
                c.hold    = 1'b1;
                c.target  = ST_CHECK;
            end
            ST_CHECK: begin
                c.x_sel  = XS_A;
                c.rd_sel = RS_A;
                c.cond   = CN_ERR;
                c.target = ST_PUSH;
            end
            ST_WALK_A: begin
                c.x_sel   = XS_RDATA;
                c.rd_sel  = RS_RDATA;
                c.root_ld = 1'b1;
                c.cond    = CN_AT_ROOT;
                c.hold    = 1'b1;
                c.target  = ST_SET_CA;
            end
            ST_SET_CA: begin
                c.x_sel  = XS_A;
                c.rd_sel = RS_A;
                c.ra_ld  = 1'b1;
            end
            ST_COMP_A: begin
                c.x_sel  = XS_RDATA;
                c.rd_sel = RS_RDATA;
                c.wr_sel = WS_COMPRESS;
                c.cond   = CN_X_ROOT;
                c.hold   = 1'b1;
                c.target = ST_SET_B;
            end
            ST_SET_B: begin
                c.x_sel  = XS_B;
                c.rd_sel = RS_B;
            end
            ST_WALK_B: begin
                c.x_sel   = XS_RDATA;
                c.rd_sel  = RS_RDATA;
                c.root_ld = 1'b1;
                c.cond    = CN_AT_ROOT;
                c.hold    = 1'b1;
                c.target  = ST_SET_CB;
            end
            ST_SET_CB: begin
                c.x_sel  = XS_B;
                c.rd_sel = RS_B;
                c.rb_ld  = 1'b1;
            end
            ST_COMP_B: begin
                c.x_sel  = XS_RDATA;
                c.rd_sel = RS_RDATA;
                c.wr_sel = WS_COMPRESS;
                c.cond   = CN_X_ROOT;
                c.hold   = 1'b1;
                c.target = ST_SAME;
            end
            ST_SAME: begin
                c.same_ld = 1'b1;
                c.hrd_rb  = 1'b0;
                c.cond    = CN_NO_LINK;
                c.target  = ST_PUSH;
            end
            ST_HEIGHT: begin
                c.hra_ld = 1'b1;
                c.hrd_rb = 1'b1;
            end
            ST_LINK: begin
                c.wr_sel = WS_LINK;
            end
            ST_PUSH: begin
                c.push   = 1'b1;
                c.cond   = CN_OUT_FREE;
                c.hold   = 1'b1;
                c.target = ST_IDLE;
            end
            default: begin
                c.cond   = CN_OUT_FREE;
                c.target = ST_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/ufhpc_in_if.sv */
// ufhpc_in_if: valid/ready channel carrying one union or query item
// depends on ufhpc_pkg for the index width
`default_nettype none

interface ufhpc_in_if;
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [ufhpc_pkg::INDEX_W-1:0] elem_a;
    logic [ufhpc_pkg::INDEX_W-1:0] elem_b;

    modport source (output valid, output operation, output elem_a, output elem_b,
                    input ready);
    modport sink   (input valid, input operation, input elem_a, input elem_b,
                    output ready);
endinterface

`default_nettype wire

/* rtl/ufhpc_out_if.sv */
// ufhpc_out_if: valid/ready channel carrying one result item
// no dependencies
`default_nettype none

interface ufhpc_out_if;
    logic valid;
    logic ready;
    logic same_set;
    logic merged;
    logic range_error;

    modport source (output valid, output same_set, output merged, output range_error,
                    input ready);
    modport sink   (input valid, input same_set, input merged, input range_error,
                    output ready);
endinterface

`default_nettype wire

/* rtl/union_find_height_path_compress.sv */
// union-find with union by height and path compression, one item at a time
// walk a to its root, one parent read per level, and compress that path, the same for b,
// compare the roots; a linking union then reads heights and links; range errors skip walks
// result is loaded into an output register by the push step; next item taken meanwhile
// reset: synchronous, active low; a clearing pass over all MAX_ELEMENTS entries then rewrites
// both tables, items are held off until it ends, configuration writes are taken throughout
`default_nettype none

module union_find_height_path_compress #(
    parameter int unsigned MAX_ELEMENTS = 1024
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    ufhpc_in_if.sink                           i_in,
    ufhpc_out_if.source                        o_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [ufhpc_pkg::COUNT_W-1:0] i_cfg_data
);

    // element count register
    logic [ufhpc_pkg::COUNT_W-1:0] r_count;

    // output register parts the result side from the sequencer
    logic                r_out_valid;
    ufhpc_pkg::t_result  r_out;

    ufhpc_pkg::t_ctrl    ctrl;
    ufhpc_pkg::t_status  status;
    ufhpc_pkg::t_result  result;
    logic                out_free;
    logic                push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= ufhpc_pkg::COUNT_RESET;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_data;
        end
    end

    // the output register can take a new result when empty or being drained
    assign out_free = ~r_out_valid | o_out.ready;
    assign push     = ctrl.push & out_free;

    // input side ready only in the idle step
    assign i_in.ready = ctrl.ready;

    ufhpc_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    ufhpc_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_valid     (i_in.valid),
        .i_operation (i_in.operation),
        .i_elem_a    (i_in.elem_a),
        .i_elem_b    (i_in.elem_b),
        .i_count     (r_count),
        .i_out_free  (out_free),
        .o_status    (status),
        .o_result    (result)
    );

    // result transfer: load on push, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out <= result;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.same_set    = r_out.same_set;
    assign o_out.merged      = r_out.merged;
    assign o_out.range_error = r_out.range_error;

endmodule

`default_nettype wire

/* rtl/ufhpc_seq.sv */
// ufhpc_seq: step counter, microcode lookup and conditional jumps
// depends on ufhpc_pkg (step enum, control word, rom)
`default_nettype none

module ufhpc_seq (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ufhpc_pkg::t_status i_status,
    output ufhpc_pkg::t_ctrl        o_ctrl
);

    ufhpc_pkg::t_step r_step;
    ufhpc_pkg::t_step n_step;
    logic             cond_hit;

    // control word of the current step
    always_comb begin
        o_ctrl = ufhpc_pkg::ucode(r_step);
    end

    always_comb begin
        unique case (o_ctrl.cond)
            ufhpc_pkg::CN_NEVER:    cond_hit = 1'b0;
            ufhpc_pkg::CN_ACCEPT:   cond_hit = i_status.accept;
            ufhpc_pkg::CN_ERR:      cond_hit = i_status.err;
            ufhpc_pkg::CN_AT_ROOT:  cond_hit = i_status.at_root;
            ufhpc_pkg::CN_X_ROOT:   cond_hit = i_status.x_root;
            ufhpc_pkg::CN_NO_LINK:  cond_hit = i_status.no_link;
            ufhpc_pkg::CN_LAST:     cond_hit = i_status.last;
            ufhpc_pkg::CN_OUT_FREE: cond_hit = i_status.out_free;
            default:                cond_hit = 1'b0;
        endcase
    end

    // jump on condition, else hold or fall through
    always_comb begin
        priority if (cond_hit) begin
            n_step = o_ctrl.target;
        end else if (o_ctrl.hold) begin
            n_step = r_step;
        end else begin
            n_step = ufhpc_pkg::t_step'(r_step + 4'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ufhpc_pkg::ST_CLEAR;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

`default_nettype wire

/* rtl/ufhpc_dp.sv */
// ufhpc_dp: parent and height memories, walk pointer and root registers
// depends on ufhpc_pkg; steered by the control word from ufhpc_seq
`default_nettype none

module ufhpc_dp #(
    parameter int unsigned MAX_ELEMENTS = 1024
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire ufhpc_pkg::t_ctrl                i_ctrl,
    input  wire logic                            i_valid,
    input  wire logic                            i_operation,
    input  wire logic [ufhpc_pkg::INDEX_W-1:0]   i_elem_a,
    input  wire logic [ufhpc_pkg::INDEX_W-1:0]   i_elem_b,
    input  wire logic [ufhpc_pkg::COUNT_W-1:0]   i_count,
    input  wire logic                            i_out_free,
    output ufhpc_pkg::t_status                   o_status,
    output ufhpc_pkg::t_result                   o_result
);

    localparam int unsigned AW = $clog2(MAX_ELEMENTS);
    localparam int unsigned CW = (AW + 1 > ufhpc_pkg::COUNT_W) ? AW + 1 : ufhpc_pkg::COUNT_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(MAX_ELEMENTS - 1);
    localparam logic [CW-1:0] MAX_CW   = CW'(MAX_ELEMENTS);

    localparam int unsigned HW = ufhpc_pkg::HEIGHT_W;

    logic [AW-1:0] r_parent_mem [MAX_ELEMENTS];
    logic [HW-1:0] r_height_mem [MAX_ELEMENTS];

    logic          r_op;
    logic [AW-1:0] r_a;
    logic [AW-1:0] r_b;
    logic [AW-1:0] r_x;
    logic [AW-1:0] n_x;
    logic [AW-1:0] r_root;
    logic [AW-1:0] r_ra;
    logic [AW-1:0] r_rb;
    logic [AW-1:0] r_pdata;
    logic [HW-1:0] r_hdata;
    logic [HW-1:0] r_hra;
    logic          r_same;
    logic          r_merged;
    logic          r_err;

    logic          accept;
    logic          idx_ok;
    logic [AW-1:0] raddr;
    logic [AW-1:0] hraddr;
    logic          pw_en;
    logic [AW-1:0] pw_addr;
    logic [AW-1:0] pw_data;
    logic          hw_en;
    logic [AW-1:0] hw_addr;
    logic [HW-1:0] hw_data;
    logic          ra_low;
    logic          tie;

    assign accept = i_valid & i_ctrl.ready;

    // both indices below the table size and the configured count
    assign idx_ok = (CW'(i_elem_a) < CW'(i_count)) && (CW'(i_elem_a) < MAX_CW)
                 && (CW'(i_elem_b) < CW'(i_count)) && (CW'(i_elem_b) < MAX_CW);

    always_comb begin
        unique case (i_ctrl.rd_sel)
            ufhpc_pkg::RS_A:     raddr = r_a;
            ufhpc_pkg::RS_B:     raddr = r_b;
            ufhpc_pkg::RS_RDATA: raddr = r_pdata;
            default:             raddr = r_a;
        endcase
    end

    assign hraddr = i_ctrl.hrd_rb ? r_rb : r_ra;

    always_comb begin
        unique case (i_ctrl.x_sel)
            ufhpc_pkg::XS_HOLD:  n_x = r_x;
            ufhpc_pkg::XS_A:     n_x = r_a;
            ufhpc_pkg::XS_B:     n_x = r_b;
            ufhpc_pkg::XS_RDATA: n_x = r_pdata;
            ufhpc_pkg::XS_INC:   n_x = r_x + 1'b1;
            default:             n_x = r_x;
        endcase
    end

    // link: lower root under higher, tie puts b's root under a's root
    assign ra_low = r_hra < r_hdata;
    assign tie    = r_hra == r_hdata;

    always_comb begin
        pw_en   = 1'b0;
        pw_addr = r_x;
        pw_data = r_x;
        hw_en   = 1'b0;
        hw_addr = r_x;
        hw_data = ufhpc_pkg::HEIGHT_ONE;
        unique case (i_ctrl.wr_sel)
            ufhpc_pkg::WS_NONE: begin
                pw_en = 1'b0;
            end
            ufhpc_pkg::WS_CLEAR: begin
                pw_en = 1'b1;
                hw_en = 1'b1;
            end
            ufhpc_pkg::WS_COMPRESS: begin
                pw_en   = r_x != r_root;
                pw_data = r_root;
            end
            ufhpc_pkg::WS_LINK: begin
                pw_en   = 1'b1;
                pw_addr = ra_low ? r_ra : r_rb;
                pw_data = ra_low ? r_rb : r_ra;
                hw_en   = tie && (r_hra != ufhpc_pkg::HEIGHT_MAX);
                hw_addr = r_ra;
                hw_data = r_hra + 1'b1;
            end
            default: begin
                pw_en = 1'b0;
            end
        endcase
    end

    // parent memory, registered read
    always_ff @(posedge i_clk) begin
        if (pw_en) begin
            r_parent_mem[pw_addr] <= pw_data;
        end
        r_pdata <= r_parent_mem[raddr];
    end

    // height memory, registered read
    always_ff @(posedge i_clk) begin
        if (hw_en) begin
            r_height_mem[hw_addr] <= hw_data;
        end
        r_hdata <= r_height_mem[hraddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
        end else begin
            r_x <= n_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_ctrl.load_in) begin
            r_op     <= i_operation;
            r_a      <= AW'(i_elem_a);
            r_b      <= AW'(i_elem_b);
            r_err    <= ~idx_ok;
            r_same   <= 1'b0;
            r_merged <= 1'b0;
        end
        if (i_ctrl.root_ld) begin
            r_root <= r_pdata;
        end
        if (i_ctrl.ra_ld) begin
            r_ra <= r_root;
        end
        if (i_ctrl.rb_ld) begin
            r_rb <= r_root;
        end
        if (i_ctrl.same_ld) begin
            r_same <= r_ra == r_rb;
        end
        if (i_ctrl.hra_ld) begin
            r_hra <= r_hdata;
        end
        if (i_ctrl.wr_sel == ufhpc_pkg::WS_LINK) begin
            r_merged <= 1'b1;
        end
    end

    assign o_status.accept   = accept;
    assign o_status.err      = r_err;
    assign o_status.at_root  = r_pdata == r_x;
    assign o_status.x_root   = r_x == r_root;
    assign o_status.no_link  = r_op | (r_ra == r_rb);
    assign o_status.last     = r_x == LAST_IDX;
    assign o_status.out_free = i_out_free;

    assign o_result.same_set    = r_same;
    assign o_result.merged      = r_merged;
    assign o_result.range_error = r_err;

endmodule

`default_nettype wire

/* dv/testbench.sv */
// testbench for union_find_height_path_compress: directed and random union/query traffic
// depends on ufhpc_pkg, ufhpc_in_if, ufhpc_out_if and union_find_height_path_compress from the rtl folder
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned COUNT_W      = ufhpc_pkg::COUNT_W;
    localparam int unsigned INDEX_W      = ufhpc_pkg::INDEX_W;
    localparam int unsigned HEIGHT_W     = ufhpc_pkg::HEIGHT_W;

    localparam int unsigned MAX_ELEMENTS = 1024;
    localparam int unsigned LONG_HOLD    = 400;   // cycles the receiver holds off once
    localparam int unsigned SETTLE       = 100;   // cycles watched after the last result

    typedef enum logic {
        OP_UNION = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        SINK_ALWAYS,
        SINK_COIN,
        SINK_SPARSE,
        SINK_PERIODIC
    } t_sink_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    logic [COUNT_W-1:0] cfg_data;

    ufhpc_in_if  in_ch ();
    ufhpc_out_if out_ch ();

    union_find_height_path_compress #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .o_out     (out_ch),
        .i_cfg_we  (cfg_we),
        .i_cfg_data(cfg_data)
    );

    // 10 ns clock, first rising edge at 5 ns
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow copy of the forest and the element count register
    logic [INDEX_W-1:0]  shadow_parent [MAX_ELEMENTS];
    logic [HEIGHT_W-1:0] shadow_height [MAX_ELEMENTS];
    logic [COUNT_W-1:0]  shadow_count;

    // answers predicted at input transfer, oldest first
    ufhpc_pkg::t_result answers_due [$];
    int fail_count = 0;

    // sender burst state
    int unsigned burst_left = 0;
    bit          gaps_on    = 1'b1;

    // long hold-off requests, served by the receiver process
    int unsigned hold_reqs   = 0;
    int unsigned hold_served = 0;

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // counts above the table act as the table size
    function automatic int unsigned effective_limit();
        return (shadow_count > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(shadow_count);
    endfunction

    // walk to the root, then point every node on the path straight at it
    function automatic logic [INDEX_W-1:0] find_and_compress(input logic [INDEX_W-1:0] start);
        logic [INDEX_W-1:0] root;
        logic [INDEX_W-1:0] walk;
        logic [INDEX_W-1:0] nxt;
        int unsigned        steps;
        root  = start;
        steps = 0;
        while (shadow_parent[root] != root && steps < MAX_ELEMENTS) begin
            root = shadow_parent[root];
            steps++;
        end
        walk  = start;
        steps = 0;
        while (walk != root && steps < MAX_ELEMENTS) begin
            nxt                 = shadow_parent[walk];
            shadow_parent[walk] = root;
            walk                = nxt;
            steps++;
        end
        return root;
    endfunction

    // answer of one item; updates the shadow forest like the block does
    function automatic ufhpc_pkg::t_result predict_answer(input t_op op,
                                                          input logic [INDEX_W-1:0] a,
                                                          input logic [INDEX_W-1:0] b);
        ufhpc_pkg::t_result r;
        int unsigned        limit;
        logic [INDEX_W-1:0] ra;
        logic [INDEX_W-1:0] rb;
        logic [INDEX_W-1:0] hi;
        logic [INDEX_W-1:0] lo;
        r     = '0;
        limit = effective_limit();
        // out of range: flagged, nothing touched
        if (a >= limit || b >= limit) begin
            r.range_error = 1'b1;
            return r;
        end
        ra         = find_and_compress(a);
        rb         = find_and_compress(b);
        r.same_set = (ra == rb);
        if (op == OP_UNION && ra != rb) begin
            // lower root goes under the higher; on a tie b's root goes under a's
            hi = ra;
            lo = rb;
            if (shadow_height[ra] < shadow_height[rb]) begin
                hi = rb;
                lo = ra;
            end
            shadow_parent[lo] = hi;
            // saturating height; with 1024 elements heights top out near 11
            if (shadow_height[hi] == shadow_height[lo]
                    && shadow_height[hi] < ufhpc_pkg::HEIGHT_MAX) begin
                shadow_height[hi] = shadow_height[hi] + 1'b1;
            end
            r.merged = 1'b1;
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // result checker
    // ---------------------------------------------------------------

    // values sampled at the edge are the ones from before it
    always @(posedge i_clk) begin
        ufhpc_pkg::t_result want;
        if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (answers_due.size() == 0) begin
                $error("result transfer with no answer pending");
                fail_count++;
            end else begin
                want = answers_due.pop_front();
                if (out_ch.same_set !== want.same_set) begin
                    $error("same_set expected %0d actual %0d", want.same_set, out_ch.same_set);
                    fail_count++;
                end
                if (out_ch.merged !== want.merged) begin
                    $error("merged expected %0d actual %0d", want.merged, out_ch.merged);
                    fail_count++;
                end
                if (out_ch.range_error !== want.range_error) begin
                    $error("range_error expected %0d actual %0d",
                           want.range_error, out_ch.range_error);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // receiver: stall pattern that changes mode, plus long hold-offs on request
    // ---------------------------------------------------------------

    initial begin
        t_sink_mode  sink_mode;
        int unsigned mode_left;
        int unsigned hold_left;
        int unsigned tick;
        sink_mode    = SINK_ALWAYS;
        mode_left    = 50;
        hold_left    = 0;
        tick         = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (hold_left != 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (hold_reqs != hold_served) begin
                hold_served++;
                hold_left    = LONG_HOLD;
                out_ch.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    sink_mode = t_sink_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                end else begin
                    mode_left--;
                end
                case (sink_mode)
                    SINK_ALWAYS:   out_ch.ready <= 1'b1;
                    SINK_COIN:     out_ch.ready <= $urandom_range(0, 1);
                    SINK_SPARSE:   out_ch.ready <= ($urandom_range(0, 3) == 0);
                    SINK_PERIODIC: out_ch.ready <= ((tick % 5) >= 2);
                    default:       out_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // sender and shared tasks
    // ---------------------------------------------------------------

    // one input transfer; gaps between random-length bursts when enabled
    task automatic send_item(input t_op op, input logic [INDEX_W-1:0] a,
                             input logic [INDEX_W-1:0] b);
        int unsigned        gap;
        ufhpc_pkg::t_result due;
        if (gaps_on && burst_left == 0) begin
            in_ch.valid <= 1'b0;
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5);
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left != 0) begin
            burst_left--;
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.elem_a    <= a;
        in_ch.elem_b    <= b;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        due = predict_answer(op, a, b);
        answers_due.insert(answers_due.size(), due);
    endtask

    // item inside the current window, with some full-range noise and repeats
    task automatic send_random_item(input int unsigned limit, input int unsigned base,
                                    input int unsigned span);
        t_op                op;
        logic [INDEX_W-1:0] a;
        logic [INDEX_W-1:0] b;
        op = ($urandom_range(0, 99) < 60) ? OP_UNION : OP_QUERY;
        if (limit == 0 || $urandom_range(0, 19) == 0) begin
            a = INDEX_W'($urandom_range(0, 1023));
        end else begin
            a = INDEX_W'(base + $urandom_range(0, span - 1));
        end
        if (limit == 0 || $urandom_range(0, 19) == 0) begin
            b = INDEX_W'($urandom_range(0, 1023));
        end else if ($urandom_range(0, 19) == 0) begin
            b = a;
        end else begin
            b = INDEX_W'(base + $urandom_range(0, span - 1));
        end
        send_item(op, a, b);
    endtask

    // sender pauses until every pending answer has come back
    task automatic wait_for_answers();
        in_ch.valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // count register write; only called with the block idle
    task automatic write_count(input logic [COUNT_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we       <= 1'b0;
        shadow_count = value;
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // right after reset, while the clearing pass still holds items off
    task automatic test_reset_state();
        send_item(OP_QUERY, 10'd0, 10'd0);
        send_item(OP_QUERY, 10'd0, 10'd1023);
        send_item(OP_QUERY, 10'd1023, 10'd1023);
        send_item(OP_UNION, 10'd1023, 10'd1023);
    endtask

    // tie linking, lower-under-higher, same-set unions, bit patterns
    task automatic test_union_rules();
        send_item(OP_UNION, 10'd0, 10'd1);
        send_item(OP_UNION, 10'd1, 10'd0);
        send_item(OP_UNION, 10'd2, 10'd3);
        send_item(OP_UNION, 10'd0, 10'd2);
        send_item(OP_UNION, 10'd4, 10'd0);
        send_item(OP_UNION, 10'd1023, 10'd512);
        send_item(OP_UNION, 10'd512, 10'd3);
        send_item(OP_QUERY, 10'd1023, 10'd1);
        send_item(OP_QUERY, 10'd5, 10'd1);
        send_item(OP_UNION, 10'd682, 10'd341);
    endtask

    // count at and around its limits, zero and above the table
    task automatic test_range_limits();
        wait_for_answers();
        write_count(11'd1000);
        send_item(OP_QUERY, 10'd999, 10'd0);
        send_item(OP_UNION, 10'd1000, 10'd0);
        send_item(OP_UNION, 10'd0, 10'd1023);
        wait_for_answers();
        write_count(11'd0);
        send_item(OP_QUERY, 10'd0, 10'd0);
        wait_for_answers();
        write_count(11'd1);
        send_item(OP_QUERY, 10'd0, 10'd0);
        send_item(OP_UNION, 10'd0, 10'd1);
        wait_for_answers();
        write_count(11'd2047);
        send_item(OP_QUERY, 10'd1023, 10'd1023);
    endtask

    // lowered count: valid elements still reach roots above it
    task automatic test_shrunk_count();
        send_item(OP_UNION, 10'd900, 10'd6);
        wait_for_answers();
        write_count(11'd7);
        send_item(OP_QUERY, 10'd6, 10'd5);
        send_item(OP_UNION, 10'd6, 10'd5);
        send_item(OP_QUERY, 10'd5, 10'd6);
    endtask

    // random phases over several counts, windows keep trees deep
    task automatic test_random_phases();
        logic [COUNT_W-1:0] cnt;
        int unsigned        limit;
        int unsigned        base;
        int unsigned        span;
        base = 0;
        span = 1;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0:       cnt = 11'd1024;
                1:       cnt = 11'd2047;
                2:       cnt = 11'd64;
                3:       cnt = 11'd300;
                4:       cnt = 11'd1023;
                default: cnt = COUNT_W'($urandom_range(2, 1024));
            endcase
            wait_for_answers();
            write_count(cnt);
            limit   = effective_limit();
            // one phase runs back to back with no sender idling
            gaps_on = (phase != 2);
            for (int n = 0; n < 200; n++) begin
                if (n % 40 == 0 || $urandom_range(0, 39) == 0) begin
                    span = $urandom_range(4, 64);
                    if (span > limit) begin
                        span = limit;
                    end
                    base = $urandom_range(0, limit - span);
                end
                send_random_item(limit, base, span);
            end
        end
        gaps_on = 1'b1;
    endtask

    // receiver holds off for a long stretch while items keep coming
    task automatic test_backpressure();
        int unsigned limit;
        int unsigned base;
        limit   = effective_limit();
        base    = $urandom_range(0, limit - 16);
        gaps_on = 1'b0;
        hold_reqs++;
        for (int n = 0; n < 40; n++) begin
            send_random_item(limit, base, 16);
        end
        gaps_on = 1'b1;
        wait_for_answers();
        for (int n = 0; n < 20; n++) begin
            send_random_item(limit, base, 16);
        end
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial begin
        for (int i = 0; i < MAX_ELEMENTS; i++) begin
            shadow_parent[i] = INDEX_W'(i);
            shadow_height[i] = ufhpc_pkg::HEIGHT_ONE;
        end
        shadow_count    = ufhpc_pkg::COUNT_RESET;
        i_rst_n         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_data        <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.operation <= 1'b0;
        in_ch.elem_a    <= '0;
        in_ch.elem_b    <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_union_rules();
        test_range_limits();
        test_shrunk_count();
        test_random_phases();
        test_backpressure();

        // drain, then watch for stray results
        wait_for_answers();
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial begin
        #10ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
